// ===== design/swac_pkg.sv =====
package swac_pkg;

	// Default ring depth
	localparam int WINDOW_MAX_DEF = 8;

	// Packet sizes
	localparam logic [9:0] HDR_END     = 10'd12;
	localparam logic [9:0] HDR_ACK     = 10'd8;
	localparam logic [9:0] PAYLOAD_MAX = 10'd500;

	// Input kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_RECV = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	// Result actions
	localparam logic [2:0] ACT_SEND   = 3'd0;
	localparam logic [2:0] ACT_END    = 3'd1;
	localparam logic [2:0] ACT_RESEND = 3'd2;
	localparam logic [2:0] ACT_ACK    = 3'd3;
	localparam logic [2:0] ACT_PIGGY  = 3'd4;
	localparam logic [2:0] ACT_DELIV  = 3'd5;
	localparam logic [2:0] ACT_FULL   = 3'd6;
	localparam logic [2:0] ACT_CLOSE  = 3'd7;

	// Register indexes
	localparam logic [1:0] REG_WINDOW  = 2'd0;
	localparam logic [1:0] REG_TICK    = 2'd1;
	localparam logic [1:0] REG_TIMEOUT = 2'd2;

	// One result word
	typedef struct packed {
		logic [2:0]  slot;
		logic [9:0]  len;
		logic [31:0] ackno;
		logic [31:0] seqno;
		logic [2:0]  action;
	} res_t;

	// Contents of one ring slot
	typedef struct packed {
		logic [31:0] seq;
		logic [31:0] ack;
		logic [9:0]  len;
	} slot_t;

endpackage

// ===== design/swac_cell.sv =====
module swac_cell (
	input  logic            clk,
	input  logic            wr_en,
	input  logic            ack_en,
	input  logic [31:0]     ackn,
	input  swac_pkg::slot_t wr_data,
	input  logic [31:0]     mark,
	output swac_pkg::slot_t rd_data,
	output logic            due
);
	import swac_pkg::*;

	slot_t slot_q;

	// Load a fresh slot or rewrite its piggybacked ack
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q <= wr_data;
		end else if (ack_en) begin
			slot_q.ack <= ackn;
		end
	end

	// Flag a slot that qualifies for resend
	assign due     = (slot_q.seq <= mark);
	assign rd_data = slot_q;

endmodule

// ===== design/sliding_window_arq_control.sv =====
// Sliding-window ARQ control. Takes one item at a time: local data, local end,
// received packet or timer tick (s_tuser), and returns zero or more result words
// on the master side, tlast on the final one. A received ack pops acknowledged
// slots one per cycle; a tick that expires walks the occupied slots one per cycle
// while results can be taken, through the row of slot cells. Stalls on m_tready
// can hold an item. Writing the window register empties the ring. A result word
// may wait on m_tready while the next item is taken.
module sliding_window_arq_control #(
	parameter int WINDOW_MAX = swac_pkg::WINDOW_MAX_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // length[9:0], ack_number[41:10], zero fill
	input  logic [1:0]  s_tuser,   // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // seqno[31:0], ackno[63:32], length_res[73:64],
	                               // slot[76:74], zero fill
	output logic [2:0]  m_tuser,   // action[2:0]
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);
	import swac_pkg::*;

	localparam int IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int OW = $clog2(WINDOW_MAX + 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_EXEC   = 3'd1;
	localparam logic [2:0] ST_SECOND = 3'd2;
	localparam logic [2:0] ST_POP    = 3'd3;
	localparam logic [2:0] ST_WALK   = 3'd4;
	localparam logic [2:0] ST_FLUSH  = 3'd5;

	logic [2:0]  state_q;
	logic [1:0]  kind_q;
	logic [9:0]  len_q;
	logic [31:0] ackn_q;
	logic [3:0]  window_q;
	logic [15:0] tick_q;
	logic [30:0] timeout_q;
	logic [IW-1:0] head_q, tail_q, walk_idx_q;
	logic [OW-1:0] occ_q, walk_cnt_q;
	logic [31:0] send_seq_q, expect_q, mark_q, countdown_q;
	logic        ended_q;
	res_t        sec_q;
	res_t        pend_q, out_q;
	logic        pend_v_q, out_v_q, out_last_q;

	logic [OW-1:0] size;
	logic [IW-1:0] tail_m1, head_nx, tail_nx, walk_nx, rd_idx;
	logic          space, out_free, push_ok, push_en, flush_en;
	res_t          push_res;
	logic [9:0]    pay_len, deliv_len;
	logic [31:0]   cd_new;
	logic [WINDOW_MAX-1:0] wr_en, ack_en, due;
	slot_t         cell_rd [WINDOW_MAX];
	slot_t         rd, wr_data;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;

	// Clamp the window to the ring depth
	always_comb begin
		if (window_q == 4'd0) begin
			size = OW'(1);
		end else if (32'(window_q) > 32'(WINDOW_MAX)) begin
			size = OW'(WINDOW_MAX);
		end else begin
			size = OW'(window_q);
		end
	end

	// Ring pointer arithmetic
	assign head_nx = (32'(head_q) + 32'd1 >= 32'(size)) ? '0 : head_q + IW'(1);
	assign tail_nx = (32'(tail_q) + 32'd1 >= 32'(size)) ? '0 : tail_q + IW'(1);
	assign walk_nx = (32'(walk_idx_q) + 32'd1 >= 32'(size)) ? '0 : walk_idx_q + IW'(1);
	assign tail_m1 = (tail_q == '0) ? IW'(size - OW'(1)) : tail_q - IW'(1);
	assign space   = (occ_q < size);

	// Pick the slot to read
	always_comb begin
		case (state_q)
			ST_WALK: rd_idx = walk_idx_q;
			ST_POP:  rd_idx = head_q;
			default: rd_idx = tail_m1;
		endcase
	end
	assign rd = cell_rd[rd_idx];

	assign pay_len   = (len_q > PAYLOAD_MAX) ? PAYLOAD_MAX : len_q;
	assign deliv_len = (len_q >= HDR_END) ? len_q - HDR_END : 10'd0;
	assign cd_new    = (countdown_q > 32'(tick_q)) ? countdown_q - 32'(tick_q) : 32'd0;
	assign wr_data   = '{seq: send_seq_q, ack: expect_q, len: pay_len + HDR_END};

	assign out_free = !out_v_q || m_tready;
	assign push_ok  = !pend_v_q || out_free;
	assign flush_en = (state_q == ST_FLUSH) && pend_v_q && out_free;

	// Slot cells
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		swac_cell u_cell (
			.clk     (clk),
			.wr_en   (wr_en[g]),
			.ack_en  (ack_en[g]),
			.ackn    (expect_q + 32'd1),
			.wr_data (wr_data),
			.mark    (mark_q),
			.rd_data (cell_rd[g]),
			.due     (due[g])
		);
	end

	// Form the result of this cycle and the slot writes
	always_comb begin
		push_en  = 1'b0;
		push_res = '0;
		wr_en    = '0;
		ack_en   = '0;
		case (state_q)
			ST_EXEC: begin
				if (kind_q == KIND_DATA || kind_q == KIND_END) begin
					if (!space) begin
						push_en         = 1'b1;
						push_res.action = ACT_FULL;
					end else if (kind_q == KIND_DATA) begin
						if (len_q != 10'd0) begin
							push_en     = 1'b1;
							push_res    = '{slot: 3'(tail_q), len: pay_len + HDR_END,
								ackno: expect_q, seqno: send_seq_q, action: ACT_SEND};
							wr_en[tail_q] = 1'b1;
						end
					end else begin
						push_en  = 1'b1;
						push_res = '{slot: 3'd0, len: HDR_END, ackno: expect_q,
							seqno: send_seq_q, action: ACT_END};
					end
				end else if (kind_q == KIND_RECV) begin
					if (len_q == HDR_END) begin
						push_en         = 1'b1;
						push_res.action = ACT_DELIV;
					end else if (len_q != HDR_ACK) begin
						push_en = 1'b1;
						if (occ_q == '0) begin
							push_res = '{slot: 3'd0, len: HDR_ACK, ackno: expect_q + 32'd1,
								seqno: 32'd0, action: ACT_ACK};
						end else begin
							push_res = '{slot: 3'(tail_m1), len: rd.len,
								ackno: expect_q + 32'd1, seqno: rd.seq, action: ACT_PIGGY};
							ack_en[tail_m1] = 1'b1;
						end
					end
				end
			end
			ST_SECOND: begin
				push_en  = out_free;
				push_res = sec_q;
			end
			ST_WALK: begin
				if (push_ok && due[walk_idx_q]) begin
					push_en  = 1'b1;
					push_res = '{slot: 3'(walk_idx_q), len: rd.len, ackno: rd.ack,
						seqno: rd.seq, action: ACT_RESEND};
				end
			end
			default: ;
		endcase
	end

	// Sequence the item and hold the transport state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			window_q    <= 4'd8;
			tick_q      <= 16'd10;
			timeout_q   <= 31'd200;
			head_q      <= '0;
			tail_q      <= '0;
			occ_q       <= '0;
			send_seq_q  <= 32'd1;
			expect_q    <= 32'd1;
			mark_q      <= 32'd0;
			countdown_q <= 32'd200;
			ended_q     <= 1'b0;
			walk_idx_q  <= '0;
			walk_cnt_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FLUSH;
					case (kind_q)
						KIND_DATA: begin
							if (space) begin
								ended_q <= 1'b0;
								if (len_q != 10'd0) begin
									tail_q     <= tail_nx;
									occ_q      <= occ_q + OW'(1);
									send_seq_q <= send_seq_q + 32'd1;
								end
							end
						end
						KIND_END: begin
							if (space) begin
								ended_q    <= 1'b1;
								send_seq_q <= send_seq_q + 32'd1;
							end
						end
						KIND_RECV: begin
							if (len_q == HDR_ACK) begin
								state_q <= ST_POP;
							end else if (len_q == HDR_END) begin
								if (ended_q && occ_q == '0) begin
									sec_q   <= '{slot: 3'd0, len: 10'd0, ackno: 32'd0,
										seqno: 32'd0, action: ACT_CLOSE};
									state_q <= ST_SECOND;
								end
							end else begin
								expect_q <= expect_q + 32'd1;
								sec_q    <= '{slot: 3'd0, len: deliv_len, ackno: 32'd0,
									seqno: 32'd0, action: ACT_DELIV};
								state_q  <= ST_SECOND;
							end
						end
						default: begin
							countdown_q <= cd_new;
							if (cd_new == 32'd0 && occ_q != '0) begin
								walk_idx_q <= head_q;
								walk_cnt_q <= '0;
								state_q    <= ST_WALK;
							end
						end
					endcase
				end
				ST_SECOND: begin
					if (out_free) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_POP: begin
					if (occ_q != '0 && rd.seq < ackn_q) begin
						head_q <= head_nx;
						occ_q  <= occ_q - OW'(1);
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_WALK: begin
					if (push_ok) begin
						if (walk_cnt_q == occ_q - OW'(1)) begin
							mark_q      <= rd.seq;
							countdown_q <= 32'(timeout_q);
							state_q     <= ST_FLUSH;
						end else begin
							walk_idx_q <= walk_nx;
							walk_cnt_q <= walk_cnt_q + OW'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q || out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			// Take configuration writes
			if (cfg_valid) begin
				case (cfg_index)
					REG_WINDOW: begin
						window_q <= cfg_data[3:0];
						head_q   <= '0;
						tail_q   <= '0;
						occ_q    <= '0;
					end
					REG_TICK:    tick_q    <= cfg_data[15:0];
					REG_TIMEOUT: timeout_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Latch the accepted word
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			len_q  <= s_tdata[9:0];
			ackn_q <= s_tdata[41:10];
		end
	end

	// Hold one result back until the next shows whether it is the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (push_en && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (flush_en) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			if (push_en) begin
				pend_v_q <= 1'b1;
			end else if (flush_en) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((push_en && pend_v_q) || flush_en) begin
			out_q      <= pend_q;
			out_last_q <= flush_en;
		end
		if (push_en) begin
			pend_q <= push_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_q.action;
	assign m_tdata  = {3'd0, out_q.slot, out_q.len, out_q.ackno, out_q.seqno};

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= size) else $error("occupancy beyond window");
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !pend_v_q) else $error("held result while idle");
	a_walk_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (occ_q != '0)) else $error("walk on empty ring");
`endif

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import swac_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	// One expected result word
	typedef struct {
		logic [2:0]  action;
		logic [31:0] seqno;
		logic [31:0] ackno;
		logic [9:0]  len;
		logic [2:0]  slot;
		logic        last;
	} arq_word_t;

	// Window predictor and store of expected result words
	class arq_scoreboard;
		logic [31:0] slot_seq [8];
		logic [31:0] slot_ack [8];
		logic [9:0]  slot_len [8];
		int unsigned head, tail, occ;
		logic [31:0] send_seq, expect_ack, resend_mark, countdown;
		bit          ended;
		logic [3:0]  window;
		logic [15:0] tick_interval;
		logic [30:0] timeout_period;
		arq_word_t   pending_words [$];
		int          mismatches, words_checked, resends, closes;

		function new();
			head = 0; tail = 0; occ = 0;
			send_seq = 32'd1; expect_ack = 32'd1; resend_mark = 32'd0;
			window = 4'd8; tick_interval = 16'd10; timeout_period = 31'd200;
			countdown = 32'd200; ended = 0;
		endfunction

		function int unsigned ring_size();
			if (window == 0)
				return 1;
			if (window > 8)
				return 8;
			return window;
		endfunction

		function void write_reg(logic [1:0] index, logic [30:0] value);
			if (index == REG_WINDOW) begin
				window = value[3:0];
				head = 0; tail = 0; occ = 0;
			end else if (index == REG_TICK) begin
				tick_interval = value[15:0];
			end else if (index == REG_TIMEOUT) begin
				timeout_period = value;
			end
		endfunction

		function void add_word(logic [2:0] a, logic [31:0] s, logic [31:0] k,
				logic [9:0] l, logic [2:0] sl);
			arq_word_t w;
			w.action = a; w.seqno = s; w.ackno = k; w.len = l; w.slot = sl; w.last = 0;
			pending_words.push_back(w);
		endfunction

		// Predict the words caused by one accepted item
		function void note_item(logic [1:0] kind, logic [9:0] len, logic [31:0] ackn);
			int unsigned size, i, idx, n0;
			size = ring_size();
			n0 = pending_words.size();
			head = head % size;
			tail = tail % size;
			if (kind == KIND_DATA || kind == KIND_END) begin
				if (occ >= size) begin
					add_word(ACT_FULL, '0, '0, '0, '0);
				end else if (kind == KIND_DATA) begin
					ended = 0;
					if (len > 0) begin
						if (len > PAYLOAD_MAX)
							len = PAYLOAD_MAX;
						slot_seq[tail] = send_seq;
						slot_ack[tail] = expect_ack;
						slot_len[tail] = len + HDR_END;
						add_word(ACT_SEND, send_seq, expect_ack, len + HDR_END, 3'(tail));
						tail = (tail + 1) % size;
						occ++;
						send_seq++;
					end
				end else begin
					ended = 1;
					add_word(ACT_END, send_seq, expect_ack, HDR_END, '0);
					send_seq++;
				end
			end else if (kind == KIND_RECV) begin
				if (len == HDR_ACK) begin
					while (occ > 0 && slot_seq[head] < ackn) begin
						head = (head + 1) % size;
						occ--;
					end
				end else if (len == HDR_END) begin
					add_word(ACT_DELIV, '0, '0, '0, '0);
					if (ended && occ == 0) begin
						add_word(ACT_CLOSE, '0, '0, '0, '0);
						closes++;
					end
				end else begin
					expect_ack++;
					if (occ == 0) begin
						add_word(ACT_ACK, '0, expect_ack, HDR_ACK, '0);
					end else begin
						idx = (tail + size - 1) % size;
						slot_ack[idx] = expect_ack;
						add_word(ACT_PIGGY, slot_seq[idx], expect_ack, slot_len[idx],
							3'(idx));
					end
					add_word(ACT_DELIV, '0, '0, len >= HDR_END ? len - HDR_END : 10'd0,
						'0);
				end
			end else begin
				countdown = countdown > 32'(tick_interval) ?
					countdown - 32'(tick_interval) : 32'd0;
				if (countdown == 0 && occ > 0) begin
					idx = head;
					for (i = 0; i < occ; i++) begin
						idx = (head + i) % size;
						if (slot_seq[idx] <= resend_mark) begin
							add_word(ACT_RESEND, slot_seq[idx], slot_ack[idx],
								slot_len[idx], 3'(idx));
							resends++;
						end
					end
					resend_mark = slot_seq[idx];
					countdown = 32'(timeout_period);
				end
			end
			// Mark the final word of this item
			if (pending_words.size() > n0)
				pending_words[pending_words.size() - 1].last = 1;
		endfunction

		// Compare one accepted result word with the oldest expectation
		function void check_word(arq_word_t got);
			arq_word_t exp_w;
			words_checked++;
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected word action=%0d seq=%0d", got.action, got.seqno);
				return;
			end
			exp_w = pending_words.pop_front();
			if (got.action !== exp_w.action || got.seqno !== exp_w.seqno ||
					got.ackno !== exp_w.ackno || got.len !== exp_w.len ||
					got.slot !== exp_w.slot || got.last !== exp_w.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: exp act=%0d seq=%0h ack=%0h len=%0d slot=%0d last=%0d, got act=%0d seq=%0h ack=%0h len=%0d slot=%0d last=%0d",
						exp_w.action, exp_w.seqno, exp_w.ackno, exp_w.len, exp_w.slot,
						exp_w.last, got.action, got.seqno, got.ackno, got.len, got.slot,
						got.last);
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [79:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [30:0] cfg_data = '0;

	arq_scoreboard sb = new();
	int send_idle_pct, recv_stall_pct, items_sent, cycles;

	sliding_window_arq_control i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Result side: check accepted words, stall at random
	always @(posedge clk) begin
		arq_word_t got;
		if (m_tvalid && m_tready && arst_n) begin
			got.action = m_tuser;
			got.seqno = m_tdata[31:0];
			got.ackno = m_tdata[63:32];
			got.len = m_tdata[73:64];
			got.slot = m_tdata[76:74];
			got.last = m_tlast;
			sb.check_word(got);
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_stall_pct);
	end

	// Present one configuration word and hold until taken
	task automatic cfg_write(logic [1:0] index, logic [30:0] value);
		cfg_valid <= 1;
		cfg_index <= index;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(index, value);
	endtask

	task automatic cfg_done();
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	// Present one input word, idling first at random
	task automatic push_item(logic [1:0] kind, logic [9:0] len, logic [31:0] ackn);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {6'd0, ackn, len};
		do @(posedge clk); while (!s_tready);
		sb.note_item(kind, len, ackn);
		items_sent++;
	endtask

	// Hold the sender until every expected word has come, then let the block settle
	task automatic drain();
		s_tvalid <= 0;
		do @(posedge clk); while (sb.pending_words.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// Mostly well-formed traffic around the live sequence range
	task automatic random_item();
		int unsigned r;
		logic [31:0] ackn;
		r = $urandom_range(99);
		ackn = sb.send_seq - $urandom_range(0, 4);
		if ($urandom_range(9) == 0)
			ackn = $urandom;
		if (r < 35)
			push_item(KIND_DATA, $urandom_range(9) == 0 ? 10'($urandom_range(1023)) :
				10'($urandom_range(1, 60)), $urandom);
		else if (r < 40)
			push_item(KIND_END, 10'($urandom), $urandom);
		else if (r < 55)
			push_item(KIND_RECV, HDR_ACK, ackn);
		else if (r < 62)
			push_item(KIND_RECV, HDR_END, $urandom);
		else if (r < 78)
			push_item(KIND_RECV, $urandom_range(9) == 0 ? 10'($urandom_range(1023)) :
				10'($urandom_range(13, 80)), $urandom);
		else
			push_item(KIND_TICK, 10'($urandom), $urandom);
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Small ring, countdown that expires at once
		cfg_write(REG_TIMEOUT, 31'h7FFF_FFFF);
		cfg_write(REG_TIMEOUT, 31'd1);
		cfg_write(REG_TICK, 31'hFFFF);
		cfg_write(REG_WINDOW, 31'd3);
		cfg_done();

		// Directed: fill, overflow, resend, piggyback, acks, end and close
		push_item(KIND_DATA, 10'd0, 32'd0);
		push_item(KIND_DATA, 10'd1, 32'hFFFF_FFFF);
		push_item(KIND_DATA, 10'd500, 32'd0);
		push_item(KIND_DATA, 10'd1023, 32'd0);
		push_item(KIND_DATA, 10'd5, 32'd0);
		push_item(KIND_END, 10'd0, 32'd0);
		push_item(KIND_TICK, 10'd0, 32'd0);
		push_item(KIND_TICK, 10'h3FF, 32'd0);
		push_item(KIND_RECV, 10'd20, 32'd0);
		push_item(KIND_RECV, 10'd5, 32'd0);
		push_item(KIND_RECV, 10'd0, 32'd0);
		push_item(KIND_RECV, HDR_END, 32'd0);
		push_item(KIND_RECV, HDR_ACK, 32'd3);
		push_item(KIND_TICK, 10'd0, 32'd0);
		push_item(KIND_RECV, HDR_ACK, 32'hFFFF_FFFF);
		push_item(KIND_TICK, 10'd0, 32'd0);
		push_item(KIND_END, 10'd0, 32'd0);
		push_item(KIND_RECV, HDR_END, 32'd0);
		push_item(KIND_RECV, 10'd1023, 32'd0);
		push_item(KIND_RECV, 10'd12 + 10'd1, 32'd0);
		push_item(KIND_DATA, 10'd0, 32'd0);
		push_item(KIND_RECV, HDR_END, 32'd0);
		drain();

		// Phase one: window above the ring depth, sender idles less than receiver
		cfg_write(REG_WINDOW, 31'd15);
		cfg_write(REG_TICK, 31'd60);
		cfg_write(REG_TIMEOUT, 31'd240);
		cfg_done();
		send_idle_pct = 29;
		recv_stall_pct = 48;
		repeat (60) random_item();
		drain();
		repeat (60) random_item();
		drain();

		// Phase two: window of zero acts as one, slowest tick
		cfg_write(REG_WINDOW, 31'd0);
		cfg_write(REG_TICK, 31'd1);
		cfg_write(REG_TIMEOUT, 31'd2);
		cfg_done();
		send_idle_pct = 48;
		recv_stall_pct = 29;
		repeat (120) random_item();
		drain();

		// Phase three: full pressure, mid-sized ring
		cfg_write(REG_WINDOW, 31'd5);
		cfg_write(REG_TICK, 31'd100);
		cfg_write(REG_TIMEOUT, 31'd300);
		cfg_done();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (120) random_item();
		drain();

		$display("Ran %0d items, checked %0d words (%0d resends, %0d closes)",
			items_sent, sb.words_checked, sb.resends, sb.closes);
		$display("Window settings 3, 15, 0 and 5; %0d mismatches", sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
